/* src/bmi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package bmi_pkg;
  localparam int TableDepth = 1024;
  localparam int AddrW = $clog2(TableDepth);
  localparam int CntW = 11;
  localparam int GenW = 32;
  localparam int PhyW = 31;
  localparam int QueueDepth = 2;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [GenW-1:0] gen;
    logic [PhyW-1:0] phy;
  } load_t;

  typedef struct packed {
    logic [GenW-1:0] q;
  } query_t;
endpackage
`default_nettype wire

/* src/bmi_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface bmi_in_if;
  import bmi_pkg::*;
  logic valid;
  logic ready;
  logic func;
  logic [AddrW-1:0] entry_index;
  logic [GenW-1:0] entry_genetic;
  logic [PhyW-1:0] entry_physical;
  logic [GenW-1:0] query_genetic;
  modport source (output valid, func, entry_index, entry_genetic, entry_physical,
    query_genetic, input ready);
  modport sink (input valid, func, entry_index, entry_genetic, entry_physical,
    query_genetic, output ready);
endinterface

interface bmi_out_if;
  import bmi_pkg::*;
  logic valid;
  logic ready;
  logic [PhyW-1:0] physical_position;
  logic below_first;
  logic beyond_last;
  modport source (output valid, physical_position, below_first, beyond_last,
    input ready);
  modport sink (input valid, physical_position, below_first, beyond_last,
    output ready);
endinterface
`default_nettype wire

/* src/bmi_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module bmi_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/bmi_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module bmi_front import bmi_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  bmi_in_if.sink         in_ch,
  input  wire logic      back_idle,
  output logic           ld_valid,
  output load_t          ld,
  output logic           q_push,
  output query_t         q_data,
  input  wire logic      q_full
);
  // Loads retire here, queries go to the queue.
  // Hold a load until no query is queued or in flight, so it never changes
  // the table under an earlier query.
  assign in_ch.ready = (in_ch.func == FUNC_LOAD) ? back_idle : !q_full;
  always_comb begin
    ld_valid = in_ch.valid && in_ch.ready && (in_ch.func == FUNC_LOAD);
    ld.addr = in_ch.entry_index;
    ld.gen = in_ch.entry_genetic;
    ld.phy = in_ch.entry_physical;
    q_push = in_ch.valid && in_ch.ready && (in_ch.func == FUNC_QUERY);
    q_data.q = in_ch.query_genetic;
  end
  logic unused;
  assign unused = rst ^ clk;
endmodule
`default_nettype wire

/* src/bmi_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module bmi_queue import bmi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  query_t    din,
  output logic      full,
  output logic      nonempty,
  input  wire logic pop,
  output query_t    dout
);
  localparam int PW = $clog2(QueueDepth);
  query_t buf_q [QueueDepth];
  logic [PW-1:0] wp, rp;
  logic [PW:0] cnt;
  assign full = (cnt == (PW+1)'(QueueDepth));
  assign nonempty = (cnt != '0);
  assign dout = buf_q[rp];
  always_ff @(posedge clk) begin
    if (push) buf_q[wp] <= din;
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

/* src/bmi_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module bmi_back import bmi_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [CntW-1:0] count_reg,
  input  wire logic            ld_valid,
  input  load_t                ld,
  input  wire logic            q_nonempty,
  input  query_t               q_data,
  output logic                 q_pop,
  output logic                 idle,
  bmi_out_if.source            out_ch
);
  localparam logic [3:0] S_IDLE = 4'd0, S_RD0 = 4'd1, S_CHK0 = 4'd2, S_CHKN = 4'd3,
    S_PROBE = 4'd4, S_PCHK = 4'd5, S_RDK = 4'd6, S_GK1 = 4'd7, S_PREP = 4'd8,
    S_MUL = 4'd9, S_DIV = 4'd10, S_FIN = 4'd11, S_OUT = 4'd12, S_PROD = 4'd13;
  localparam int DivW = 64;

  logic [3:0] state;
  logic [AddrW-1:0] raddr;
  logic [GenW-1:0] g_rd;
  logic [PhyW-1:0] p_rd;
  logic [GenW-1:0] q, g0, g1, span, off;
  logic [PhyW-1:0] p0, p1, first_p, res, mag;
  logic [AddrW:0] n, lo, hi, mid;
  logic neg, flag_b, flag_e;
  logic [DivW-1:0] num, quo;
  logic [GenW:0] rem;
  logic [6:0] step;
  logic [GenW:0] rem_sh;

  bmi_ram #(.Width(GenW), .Depth(TableDepth)) u_gen (
    .clk, .we(ld_valid), .waddr(ld.addr), .wdata(ld.gen), .raddr, .rdata(g_rd));
  bmi_ram #(.Width(PhyW), .Depth(TableDepth)) u_phy (
    .clk, .we(ld_valid), .waddr(ld.addr), .wdata(ld.phy), .raddr, .rdata(p_rd));

  // clamp the entry count to 2..TableDepth
  logic [AddrW:0] n_clamp;
  always_comb begin
    priority if (count_reg < CntW'(2)) n_clamp = (AddrW+1)'(2);
    else if (count_reg > CntW'(TableDepth)) n_clamp = (AddrW+1)'(TableDepth);
    else n_clamp = (AddrW+1)'(count_reg);
  end

  assign mid = (lo + hi) >> 1;
  assign q_pop = (state == S_IDLE) && q_nonempty;
  assign idle = (state == S_IDLE) && !q_nonempty;
  assign rem_sh = {rem[GenW-1:0], num[DivW-1]};
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.physical_position = res;
  assign out_ch.below_first = flag_b;
  assign out_ch.beyond_last = flag_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (q_nonempty) begin
          q <= q_data.q; n <= n_clamp; raddr <= '0; state <= S_RD0;
        end
        S_RD0: begin
          raddr <= AddrW'(n - 1'b1); state <= S_CHK0;
        end
        S_CHK0: begin
          g0 <= g_rd; first_p <= p_rd; state <= S_CHKN;
        end
        S_CHKN: begin
          priority if (q < g0) begin
            res <= first_p; flag_b <= 1'b1; flag_e <= 1'b0; state <= S_OUT;
          end else if (q > g_rd) begin
            res <= p_rd; flag_b <= 1'b0; flag_e <= 1'b1; state <= S_OUT;
          end else if (q == g0) begin
            res <= first_p; flag_b <= 1'b0; flag_e <= 1'b0; state <= S_OUT;
          end else begin
            flag_b <= 1'b0; flag_e <= 1'b0;
            lo <= (AddrW+1)'(1); hi <= n - 1'b1; state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (lo < hi) begin
            raddr <= AddrW'(mid); state <= S_PCHK;
          end else begin
            raddr <= AddrW'(lo); state <= S_RDK;
          end
        end
        S_PCHK: state <= S_GK1;
        S_GK1: begin
          // g_rd holds the probed breakpoint
          if (g_rd < q) lo <= mid + 1'b1;
          else hi <= mid;
          state <= S_PROBE;
        end
        S_RDK: begin
          raddr <= AddrW'(lo - 1'b1); state <= S_PREP;
        end
        S_PREP: begin
          g1 <= g_rd; p1 <= p_rd; state <= S_MUL;
        end
        S_MUL: begin
          g0 <= g_rd; p0 <= p_rd;
          if (g1 <= g_rd || q <= g_rd) begin
            res <= p_rd; state <= S_OUT;
          end else begin
            span <= g1 - g_rd;
            neg <= p1 < p_rd;
            mag <= (p1 < p_rd) ? (p_rd - p1) : (p1 - p_rd);
            // offset clamped to the span
            off <= ((q - g_rd) > (g1 - g_rd)) ? (g1 - g_rd) : (q - g_rd);
            state <= S_PROD;
          end
        end
        S_PROD: begin
          num <= DivW'(mag) * DivW'(off);
          rem <= '0;
          step <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (step == 7'(DivW)) begin
            state <= S_FIN;
          end else begin
            step <= step + 1'b1;
            num <= {num[DivW-2:0], 1'b0};
            if (rem_sh >= {1'b0, span}) begin
              rem <= rem_sh - {1'b0, span}; quo <= {quo[DivW-2:0], 1'b1};
            end else begin
              rem <= rem_sh; quo <= {quo[DivW-2:0], 1'b0};
            end
          end
        end
        S_FIN: begin
          if (neg) res <= p0 - PhyW'(quo) - PhyW'(rem != '0);
          else res <= p0 + PhyW'(quo);
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* src/breakpoint_map_interpolator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Payload
// in_ch     in   func, entry_index, entry_genetic, entry_physical, query_genetic
// out_ch    out  physical_position, below_first, beyond_last
// cfg       in   cfg_we / cfg_data: entries_in_use
// Loads wait until no query is queued or in flight, then write the table in
// the cycle they are accepted and give no item.
// A query runs from leaving the queue to its item through the one-read-port
// table search, one probe at a time, and the 64-step bit-serial divider.
// Points below, beyond or on the first breakpoint skip the search and the
// divider; a flat or backward span skips only the divider.
// Reset (rst, synchronous) empties the queue and idles the back end.
// Up to two queries wait in the queue while the back end or out_ch stalls.
module breakpoint_map_interpolator_unit import bmi_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  bmi_in_if.sink               in_ch,
  bmi_out_if.source            out_ch,
  input  wire logic            cfg_we,
  input  wire logic [CntW-1:0] cfg_data
);
  logic [CntW-1:0] count_reg;
  logic ld_valid, q_push, q_full, q_nonempty, q_pop, back_idle;
  load_t ld;
  query_t q_in, q_out;

  // hold the entry count register
  always_ff @(posedge clk) begin
    if (rst) count_reg <= CntW'(2);
    else if (cfg_we) count_reg <= cfg_data;
  end

  bmi_front u_front (.clk, .rst, .in_ch, .back_idle, .ld_valid, .ld, .q_push,
    .q_data(q_in), .q_full);
  bmi_queue u_queue (.clk, .rst, .push(q_push), .din(q_in), .full(q_full),
    .nonempty(q_nonempty), .pop(q_pop), .dout(q_out));
  bmi_back u_back (.clk, .rst, .count_reg, .ld_valid, .ld, .q_nonempty,
    .q_data(q_out), .q_pop, .idle(back_idle), .out_ch);
endmodule
`default_nettype wire
